### rtl/fqwd_pkg.sv
// Shared types and codes for the FIFO queue with delete-by-value.
package fqwd_pkg;

    // Fixed field widths of the request and result items
    localparam int REQ_W = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    // Request types
    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [VAL_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] out_value;
        logic [CNT_W-1:0] entry_count;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic            load;       // capture the request
        logic            enq;        // write at tail, grow
        logic            scan_start; // point the scan at the oldest entry
        logic            step;       // read the next entry, advance scan
        logic            shift_wr;   // move the read entry one slot toward head
        logic            pop_head;   // drop the oldest entry, return it
        logic            pop_tail;   // drop the newest slot after a delete
        logic            finish;     // present the result
        logic [ST_W-1:0] status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             full;
        logic             match;  // entry read this cycle equals the key
        logic             last;   // scan is at the newest entry
    } t_stat;

endpackage

### rtl/fqwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fqwd_ctrl.sv
// Request sequencer: dispatch, dequeue read, delete scan and gap-closing shift.
module fqwd_ctrl
    import fqwd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_DEQ      = 5'b00100,
        S_SCAN     = 5'b01000,
        S_SHIFT    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req)
                    REQ_ENQUEUE: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                        if (i_stat.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.enq    = 1'b1;
                            cmd.status = ST_OK;
                        end
                    end
                    REQ_DEQUEUE: begin
                        // read of the head slot is issued by default
                        if (i_stat.empty) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_EMPTY;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_DEQ;
                        end
                    end
                    REQ_DELETE: begin
                        if (i_stat.empty) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_NOT_FOUND;
                            n_state    = S_IDLE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        // unused request type: no change
                        cmd.finish = 1'b1;
                        cmd.status = ST_OK;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_DEQ: begin
                cmd.pop_head = 1'b1;
                cmd.finish   = 1'b1;
                cmd.status   = ST_OK;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    if (i_stat.last) begin
                        // match on the newest entry: nothing to shift
                        cmd.pop_tail = 1'b1;
                        cmd.finish   = 1'b1;
                        cmd.status   = ST_OK;
                        n_state      = S_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                        n_state  = S_SHIFT;
                    end
                end else if (i_stat.last) begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                cmd.shift_wr = 1'b1;
                if (i_stat.last) begin
                    cmd.pop_tail = 1'b1;
                    cmd.finish   = 1'b1;
                    cmd.status   = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/fqwd_dp.sv
// Datapath: circular entry store, pointers, count, scan position and result.
module fqwd_dp
    import fqwd_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_req,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]          r_head, r_tail, r_ptr, r_wptr, r_idx;
    logic [CW-1:0]          r_count, n_count;
    logic [REQ_W-1:0]       r_req;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_done;
    t_out_item              r_result;

    logic [AW-1:0]            ptr_next, raddr, waddr;
    logic                     we;
    logic [VALUE_WIDTH-1:0]   wdata, rdata;
    logic [VALUE_WIDTH+VAL_W-1:0] val_ext, rd_ext;
    logic [CW+CNT_W-1:0]      cnt_ext;

    // Advance a slot index around the ring
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign ptr_next = wrap_inc(r_ptr);

    // Store access: scan reads follow the scan pointer, otherwise the head
    assign raddr = i_cmd.step ? ptr_next : r_head;
    assign we    = i_cmd.enq | i_cmd.shift_wr;
    assign waddr = i_cmd.enq ? r_tail : r_wptr;
    assign wdata = i_cmd.enq ? r_val : rdata;

    fqwd_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Width fitting of the value fields
    assign val_ext = {{VALUE_WIDTH{1'b0}}, i_req.item_value};
    assign rd_ext  = {{VAL_W{1'b0}}, rdata};

    // Count after this cycle's update
    always_comb begin
        n_count = r_count;
        if (i_cmd.enq) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_head || i_cmd.pop_tail) begin
            n_count = r_count - CW'(1);
        end
    end

    assign cnt_ext = {{CNT_W{1'b0}}, n_count};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
            if (i_cmd.enq) begin
                r_tail <= wrap_inc(r_tail);
            end else if (i_cmd.pop_tail) begin
                r_tail <= r_ptr;
            end
            if (i_cmd.pop_head) begin
                r_head <= wrap_inc(r_head);
            end
        end
    end

    // Request capture, scan position and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req.req_type;
            r_val <= val_ext[VALUE_WIDTH-1:0];
        end
        if (i_cmd.scan_start) begin
            r_ptr <= r_head;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_wptr <= r_ptr;
            r_ptr  <= ptr_next;
            r_idx  <= r_idx + AW'(1);
        end
        if (i_cmd.finish) begin
            r_result.status      <= i_cmd.status;
            r_result.out_value   <= i_cmd.pop_head ? rd_ext[VAL_W-1:0] : '0;
            r_result.entry_count <= cnt_ext[CNT_W-1:0];
        end
    end

    assign o_stat.req   = r_req;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.match = (rdata == r_val);
    assign o_stat.last  = ((CW'(r_idx) + CW'(1)) == r_count);

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### rtl/fifo_queue_with_delete.sv
// FIFO queue with delete-by-value: top level joining sequencer and datapath.
// The registered result strobe follows the dispatch state for enqueue and for any
// flagged empty queue, the dequeue state for dequeue, and the scan and shift for
// delete, which move one entry per cycle through the store's single read port.
// busy stays high until the result cycle; a new request is taken in that cycle.
// Synchronous active-low reset empties the queue; store contents are not cleared.
module fifo_queue_with_delete
    import fqwd_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_req,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    fqwd_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (ctrl_busy)
    );

    fqwd_dp #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_done  (o_done),
        .o_result(o_result)
    );

    assign busy = ctrl_busy;

endmodule
